/* hdl/viterbi_decoder_16_state_top_assert.svh */
`ifndef VITERBI_DECODER_16_STATE_TOP_ASSERT_SVH
`define VITERBI_DECODER_16_STATE_TOP_ASSERT_SVH

// plain invariant, sampled on the rising edge, off during reset
`define VD16_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vd16 check failed");

// implication into the next cycle
`define VD16_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vd16 check failed");

`endif

/* hdl/vd16_pkg.sv */
package vd16_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int NUM_STATES  = 16;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int METRIC_W    = $clog2(2 * MAX_SYMBOLS + 1);
    localparam int PATH_BYTES  = (MAX_SYMBOLS + 7) / 8;
    localparam int PATH_W      = PATH_BYTES * 8;
    localparam int BYTES_W     = $clog2(PATH_BYTES + 1);
    localparam int OUT_METRIC_W = 10;
    localparam int METRIC_SAT  = 1023;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last_symbol;
    } in_item_t;

    typedef struct packed {
        logic [7:0]              data_byte;
        logic                    last_byte;
        logic [OUT_METRIC_W-1:0] path_metric;
        logic                    overflow;
    } out_item_t;

    typedef struct packed {
        logic acs_en;
        logic ovf_set;
        logic search_en;
        logic load;
        logic shift;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic search_done;
        logic last_out;
    } dp_status_t;

endpackage

/* hdl/viterbi_decoder_16_state_top.sv */
// channel   direction  payload            handshake
// in        into       in_data (symbol)   in_valid / in_ready
// out       out of     out_data (byte)    out_valid / out_ready
// cfg       into       cfg_data (64 bit)  cfg_valid / cfg_ready
//
// one cycle per received symbol: all 16 add-compare-select units update together
// frame end: a lowest-metric search over all 16 states, a load of the survivor,
// then one byte per out transfer, ceil(symbols / 8) bytes
// in_ready is low from the last symbol until the final byte transfer
// asynchronous active-low reset clears metrics, paths, count and table
module viterbi_decoder_16_state_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vd16_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vd16_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [63:0]         cfg_data
);

    logic [63:0]          table_reg;
    vd16_pkg::dp_cmd_t    cmd;
    vd16_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= '0;
        end
        else if (cfg_valid)
        begin
            table_reg <= cfg_data;
        end
    end

    vd16_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_symbol),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    vd16_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_bits (table_reg),
        .symbol     (in_data.symbol),
        .cmd        (cmd),
        .status     (status),
        .out_item   (out_data)
    );

endmodule

/* hdl/vd16_ctrl.sv */
module vd16_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  vd16_pkg::dp_status_t status,
    output vd16_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_LOAD   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acs_en  = !status.full;
                    cmd.ovf_set = status.full;
                    if (in_last)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_en = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last_out)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.shift = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

/* hdl/vd16_datapath.sv */
module vd16_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [63:0]          table_bits,
    input  logic [1:0]           symbol,
    input  vd16_pkg::dp_cmd_t    cmd,
    output vd16_pkg::dp_status_t status,
    output vd16_pkg::out_item_t  out_item
);

    localparam int NS = vd16_pkg::NUM_STATES;
    localparam int MW = vd16_pkg::METRIC_W;
    localparam int PW = vd16_pkg::PATH_W;

    logic [MW-1:0] metric_reg [NS];
    logic [MW-1:0] metric_next [NS];
    logic [PW-1:0] path_reg [NS];
    logic [PW-1:0] path_next [NS];
    logic [vd16_pkg::CNT_W-1:0] count_reg;
    logic ovf_reg;

    logic [vd16_pkg::STATE_W-1:0] idx_reg;
    logic [vd16_pkg::STATE_W-1:0] best_idx_reg;
    logic [MW-1:0]                best_metric_reg;

    logic [PW-1:0]                  shift_reg;
    logic [vd16_pkg::BYTES_W-1:0]   bytes_left_reg;
    logic [vd16_pkg::OUT_METRIC_W-1:0] out_metric_reg;
    logic                           out_ovf_reg;

    logic [PW-1:0] bit_mask;
    logic [vd16_pkg::CNT_W:0] count_round;

    assign bit_mask = PW'(1) << count_reg;

    // one add-compare-select unit per state
    for (genvar i = 0; i < NS; i++)
    begin : g_acs
        localparam int P0  = (i << 1) & (NS - 2);
        localparam int P1  = P0 | 1;
        localparam int BIT = (i >> (vd16_pkg::STATE_W - 1)) & 1;
        logic [1:0] exp0;
        logic [1:0] exp1;
        logic [1:0] d0;
        logic [1:0] d1;
        logic [MW-1:0] m0;
        logic [MW-1:0] m1;
        logic take1;

        assign exp0  = table_bits[2 * (2 * P0 + BIT) +: 2];
        assign exp1  = table_bits[2 * (2 * P1 + BIT) +: 2];
        assign d0    = 2'((symbol[0] ^ exp0[0])) + 2'((symbol[1] ^ exp0[1]));
        assign d1    = 2'((symbol[0] ^ exp1[0])) + 2'((symbol[1] ^ exp1[1]));
        assign m0    = metric_reg[P0] + MW'(d0);
        assign m1    = metric_reg[P1] + MW'(d1);
        assign take1 = m1 < m0;

        always_comb
        begin
            metric_next[i] = take1 ? m1 : m0;
            path_next[i]   = take1 ? path_reg[P1] : path_reg[P0];
            if (BIT == 1)
            begin
                path_next[i] = path_next[i] | bit_mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                metric_reg[s] <= '0;
                path_reg[s]   <= '0;
            end
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.acs_en)
            begin
                for (int s = 0; s < NS; s++)
                begin
                    metric_reg[s] <= metric_next[s];
                    path_reg[s]   <= path_next[s];
                end
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.load)
            begin
                for (int s = 0; s < NS; s++)
                begin
                    metric_reg[s] <= '0;
                    path_reg[s]   <= '0;
                end
                count_reg <= '0;
            end
            if (cmd.ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
            else if (cmd.load)
            begin
                ovf_reg <= 1'b0;
            end
            if (cmd.search_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign count_round = ({1'b0, count_reg} + (vd16_pkg::CNT_W + 1)'(7)) >> 3;

    // lowest metric search, one state per cycle, ties keep the lower index
    always_ff @(posedge clk)
    begin
        if (cmd.search_en)
        begin
            if (idx_reg == '0 || metric_reg[idx_reg] < best_metric_reg)
            begin
                best_metric_reg <= metric_reg[idx_reg];
                best_idx_reg    <= idx_reg;
            end
        end
        if (cmd.load)
        begin
            shift_reg      <= path_reg[best_idx_reg];
            bytes_left_reg <= vd16_pkg::BYTES_W'(count_round);
            out_ovf_reg    <= ovf_reg;
            if (32'(best_metric_reg) > 32'(vd16_pkg::METRIC_SAT))
            begin
                out_metric_reg <= vd16_pkg::OUT_METRIC_W'(vd16_pkg::METRIC_SAT);
            end
            else
            begin
                out_metric_reg <= vd16_pkg::OUT_METRIC_W'(best_metric_reg);
            end
        end
        else if (cmd.shift)
        begin
            shift_reg      <= shift_reg >> 8;
            bytes_left_reg <= bytes_left_reg - 1'b1;
        end
    end

    // first decoded bit of the byte goes to bit 7
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            out_item.data_byte[7 - b] = shift_reg[b];
        end
    end

    assign out_item.last_byte   = status.last_out;
    assign out_item.path_metric = out_metric_reg;
    assign out_item.overflow    = out_ovf_reg;

    assign status.full        = count_reg == vd16_pkg::CNT_W'(vd16_pkg::MAX_SYMBOLS);
    assign status.search_done = idx_reg == vd16_pkg::STATE_W'(NS - 1);
    assign status.last_out    = bytes_left_reg == vd16_pkg::BYTES_W'(1);

endmodule

/* hdl/vd16_checker.sv */
`include "viterbi_decoder_16_state_top_assert.svh"

module vd16_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input vd16_pkg::out_item_t out_data
);

    // input is closed while a frame is being emitted
    `VD16_ASSERT(a_no_overlap, !(in_ready && out_valid))

    // frame-wide fields hold across the bytes of one frame
    `VD16_ASSERT_NEXT(a_frame_fields, out_valid && out_ready && !out_data.last_byte, out_valid && $stable(out_data.path_metric) && $stable(out_data.overflow))

    // after the final byte the decoder takes symbols again
    `VD16_ASSERT_NEXT(a_frame_done, out_valid && out_ready && out_data.last_byte, in_ready && !out_valid)

    // a stalled byte holds
    `VD16_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind viterbi_decoder_16_state_top vd16_checker u_vd16_checker (.*);

/* bench/viterbi_decoder_16_state_top_test.sv */
`timescale 1ns / 100ps

module viterbi_decoder_16_state_top_test;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    vd16_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    vd16_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [63:0]         cfg_data;

    // decoder state as predicted
    logic [63:0]                 trellis_table;
    int unsigned                 state_metric [vd16_pkg::NUM_STATES];
    logic [vd16_pkg::PATH_W-1:0] state_path [vd16_pkg::NUM_STATES];
    int unsigned                 symbols_held;
    bit                          symbols_dropped;

    vd16_pkg::out_item_t expected_bytes [$];
    int          mismatches;
    int          bytes_checked;
    int          frames_sent;
    int          symbols_sent;
    bit          quiet;
    bit          byte_taken;
    int          ready_stall;

    viterbi_decoder_16_state_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int draw_wait();
        if (quiet)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic int unsigned hamming2(logic [1:0] a, logic [1:0] b);
        logic [1:0] d;
        d = a ^ b;
        return d[0] + d[1];
    endfunction

    task automatic clear_trellis();
        for (int s = 0; s < vd16_pkg::NUM_STATES; s++)
        begin
            state_metric[s] = 0;
            state_path[s]   = '0;
        end
        symbols_held    = 0;
        symbols_dropped = 1'b0;
    endtask

    // add-compare-select over all states, then trace out on the final symbol
    task automatic decode_symbol(vd16_pkg::in_item_t item);
        int unsigned next_metric [vd16_pkg::NUM_STATES];
        logic [vd16_pkg::PATH_W-1:0] next_path [vd16_pkg::NUM_STATES];
        int unsigned prev;
        int unsigned cand;
        int unsigned best;
        int unsigned nbytes;
        int unsigned metric;
        logic bitv;
        vd16_pkg::out_item_t o;
        if (symbols_held < vd16_pkg::MAX_SYMBOLS)
        begin
            for (int s = 0; s < vd16_pkg::NUM_STATES; s++)
            begin
                bitv = s[3];
                for (int k = 0; k < 2; k++)
                begin
                    prev = ((s << 1) & 14) | k;
                    cand = state_metric[prev] +
                           hamming2(item.symbol, trellis_table[2 * (2 * prev + bitv) +: 2]);
                    // strict less keeps the even predecessor on a tie
                    if (k == 0 || cand < next_metric[s])
                    begin
                        next_metric[s] = cand;
                        next_path[s]   = state_path[prev];
                    end
                end
                next_path[s][vd16_pkg::PATH_W - 1 - symbols_held] = bitv;
            end
            for (int s = 0; s < vd16_pkg::NUM_STATES; s++)
            begin
                state_metric[s] = next_metric[s];
                state_path[s]   = next_path[s];
            end
            symbols_held++;
        end
        else
            symbols_dropped = 1'b1;
        if (!item.last_symbol)
            return;
        best = 0;
        for (int s = 1; s < vd16_pkg::NUM_STATES; s++)
            if (state_metric[s] < state_metric[best])
                best = s;
        metric = (state_metric[best] > vd16_pkg::METRIC_SAT) ?
                 vd16_pkg::METRIC_SAT : state_metric[best];
        nbytes = (symbols_held + 7) / 8;
        for (int b = 0; b < nbytes; b++)
        begin
            o.data_byte   = state_path[best][vd16_pkg::PATH_W - 1 - 8 * b -: 8];
            o.last_byte   = (b + 1 == nbytes);
            o.path_metric = vd16_pkg::OUT_METRIC_W'(metric);
            o.overflow    = symbols_dropped;
            expected_bytes.push_back(o);
        end
        clear_trellis();
        frames_sent++;
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // called at a rising edge; leaves in_valid high after the transfer
    task automatic send_symbol(logic [1:0] sym, logic last);
        int gap;
        vd16_pkg::in_item_t item;
        gap = draw_wait();
        item.symbol      = sym;
        item.last_symbol = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        symbols_sent++;
        decode_symbol(item);
    endtask

    task automatic send_frame(int len, bit random_syms, logic [1:0] fixed_sym);
        for (int n = 0; n < len; n++)
            send_symbol(random_syms ? 2'($urandom_range(0, 3)) : fixed_sym, n == len - 1);
    endtask

    // sender holds off until every expected byte has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_table(logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid     <= 1'b0;
        trellis_table = value;
    endtask

    task automatic test_single_symbols();
        write_table('0);
        for (int s = 0; s < 4; s++)
            send_frame(1, 0, 2'(s));
        send_frame(3, 0, 2'b11);
        drain();
        write_table('1);
        for (int s = 0; s < 4; s++)
            send_frame(1, 0, 2'(s));
        drain();
    endtask

    task automatic test_byte_boundaries();
        write_table(64'h5A3C_F00F_96E1_2B7D);
        send_frame(7, 1, 2'b00);
        send_frame(9, 1, 2'b00);
        send_frame(16, 1, 2'b00);
        drain();
    endtask

    task automatic test_capacity();
        write_table({$urandom, $urandom});
        // fills to capacity, then the last symbol itself is dropped but still closes the frame
        send_frame(vd16_pkg::MAX_SYMBOLS + 1, 1, 2'b00);
        drain();
    endtask

    task automatic test_random_frames(int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(1, 12);
            send_frame(len, 1, 2'b00);
            sent += len;
            if ($urandom_range(0, 4) == 0)
            begin
                drain();
                write_table({$urandom, $urandom});
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    // receiver: random stall after every byte transfer
    always @(negedge clk)
    begin
        byte_taken = rst_n && out_valid && out_ready;
        if (byte_taken)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %0h", out_data.data_byte));
            else
            begin
                vd16_pkg::out_item_t e;
                e = expected_bytes.pop_front();
                if (out_data.data_byte !== e.data_byte)
                    report_mismatch($sformatf("data_byte %0h, want %0h",
                                              out_data.data_byte, e.data_byte));
                if (out_data.last_byte !== e.last_byte)
                    report_mismatch($sformatf("last_byte %0b, want %0b",
                                              out_data.last_byte, e.last_byte));
                if (out_data.path_metric !== e.path_metric)
                    report_mismatch($sformatf("path_metric %0d, want %0d",
                                              out_data.path_metric, e.path_metric));
                if (out_data.overflow !== e.overflow)
                    report_mismatch($sformatf("overflow %0b, want %0b",
                                              out_data.overflow, e.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if (byte_taken)
            ready_stall = draw_wait();
        if (ready_stall > 0)
        begin
            ready_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        mismatches    = 0;
        bytes_checked = 0;
        frames_sent   = 0;
        symbols_sent  = 0;
        quiet         = 1'b0;
        byte_taken    = 1'b0;
        ready_stall   = 0;
        trellis_table = '0;
        clear_trellis();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_symbols();
        test_byte_boundaries();
        test_capacity();
        test_random_frames(20);
        write_table('1);
        test_random_frames(10);

        $display("covered %0d symbols in %0d frames, %0d bytes checked",
                 symbols_sent, frames_sent, bytes_checked);
        $display("incl. full and overflowing frames, all-zero and all-one tables");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/vd16_pkg.sv
hdl/vd16_ctrl.sv
hdl/vd16_datapath.sv
hdl/viterbi_decoder_16_state_top.sv
hdl/vd16_checker.sv
bench/viterbi_decoder_16_state_top_test.sv
